FILE: hw/rtl/label_propagation_components_defines.svh
// Assertion macros shared by the label propagation RTL.
`ifndef LABEL_PROPAGATION_COMPONENTS_DEFINES_SVH
`define LABEL_PROPAGATION_COMPONENTS_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LPC_ASSERT_IMP(name, ant, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("lpc assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LPC_ASSERT_NXT(name, ant, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("lpc assertion failed");

`else

`define LPC_ASSERT_IMP(name, ant, cons)
`define LPC_ASSERT_NXT(name, ant, cons)

`endif

`endif

FILE: hw/rtl/lpc_pkg.sv
// Shared types and constants for the label propagation block.
`default_nettype none

package lpc_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int NODE_W = 10;
	localparam int LABEL_W = 10;
	localparam int COUNT_W = 11;
	localparam int CFG_W = 11;
	localparam int NODE_SPAN = 1 << NODE_W;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

	// Register index, taken from the word address.
	localparam logic REG_NODE_COUNT = 1'b0;

	typedef enum logic [1:0] {
		ACT_INIT = 2'd0,
		ACT_EDGE = 2'd1,
		ACT_PASS = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		SWP_CLEAR = 2'd0,
		SWP_INIT  = 2'd1,
		SWP_PASS  = 2'd2
	} sweep_kind_t;

	typedef struct packed {
		logic        accept;
		logic        sweep_en;
		sweep_kind_t sweep_kind;
		logic        load_out;
	} lpc_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} lpc_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lpc_datapath.sv
// Label and mark memories, sweep counter, change counter and result register.
`default_nettype none

module lpc_datapath import lpc_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lpc_cmd_t           cmd,
	output lpc_status_t             status,
	input  wire logic [CFG_W-1:0]   node_count,
	input  wire logic [1:0]         action,
	input  wire logic [NODE_W-1:0]  src_node,
	input  wire logic [NODE_W-1:0]  dst_node,
	output logic [LABEL_W-1:0]      src_label,
	output logic [LABEL_W-1:0]      dst_label,
	output logic                    label_lowered,
	output logic [COUNT_W-1:0]      changed_count,
	output logic                    converged
);

	// Edges can only name the first NODE_SPAN nodes, so no more are stored.
	localparam int DEPTH = (MAX_NODES < NODE_SPAN) ? MAX_NODES : NODE_SPAN;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [LABEL_W-1:0] label_mem [DEPTH];
	logic               mark_mem  [DEPTH];

	action_t            act_q;
	logic               edge_ok_q;
	logic [ADDR_W-1:0]  src_idx_q;
	logic [ADDR_W-1:0]  dst_idx_q;
	logic [LABEL_W-1:0] src_lab_q;
	logic [LABEL_W-1:0] dst_lab_q;

	logic [ADDR_W-1:0]  sweep_q;
	logic               pass_vld_s1;
	logic               in_use_s1;
	logic               mark_s1;
	logic [COUNT_W-1:0] count_q;

	logic [ADDR_W-1:0]  src_idx;
	logic [ADDR_W-1:0]  dst_idx;
	logic               edge_ok;
	logic               lower_dst;
	logic               lower_src;
	logic [LABEL_W-1:0] min_lab;
	logic               commit;
	logic               sweep_last;

	assign src_idx = src_node[ADDR_W-1:0];
	assign dst_idx = dst_node[ADDR_W-1:0];

	assign edge_ok = ((CFG_W)'(src_node) < node_count) && ((CFG_W)'(dst_node) < node_count)
		&& (32'(src_node) < MAX_NODES) && (32'(dst_node) < MAX_NODES);

	// Only one endpoint can fall: both end up at the smaller of the two labels.
	assign lower_dst = src_lab_q < dst_lab_q;
	assign lower_src = dst_lab_q < src_lab_q;
	assign min_lab   = lower_dst ? src_lab_q : dst_lab_q;
	assign commit    = cmd.load_out && (act_q == ACT_EDGE) && edge_ok_q;

	assign sweep_last = sweep_q == ADDR_W'(DEPTH - 1);
	assign status.sweep_last = sweep_last;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q     <= action_t'(action);
			edge_ok_q <= edge_ok;
			src_idx_q <= src_idx;
			dst_idx_q <= dst_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			src_lab_q <= label_mem[src_idx];
			dst_lab_q <= label_mem[dst_idx];
		end
		if (cmd.sweep_en && (cmd.sweep_kind == SWP_INIT)) begin
			label_mem[sweep_q] <= LABEL_W'(sweep_q);
		end else if (commit && lower_dst) begin
			label_mem[dst_idx_q] <= min_lab;
		end else if (commit && lower_src) begin
			label_mem[src_idx_q] <= min_lab;
		end
	end

	// Every sweep clears the marks it passes; the pass sweep also reads them first.
	always_ff @(posedge clk) begin
		if (cmd.sweep_en) begin
			mark_s1 <= mark_mem[sweep_q];
			mark_mem[sweep_q] <= 1'b0;
		end else if (commit && lower_dst) begin
			mark_mem[dst_idx_q] <= 1'b1;
		end else if (commit && lower_src) begin
			mark_mem[src_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			pass_vld_s1 <= 1'b0;
			in_use_s1   <= 1'b0;
			count_q     <= '0;
		end else begin
			if (cmd.sweep_en) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			end
			pass_vld_s1 <= cmd.sweep_en && (cmd.sweep_kind == SWP_PASS);
			in_use_s1   <= (COUNT_W)'(sweep_q) < node_count;
			if (cmd.accept) begin
				count_q <= '0;
			end else if (pass_vld_s1 && mark_s1 && in_use_s1 && (count_q != COUNT_MAX)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			src_label     <= '0;
			dst_label     <= '0;
			label_lowered <= 1'b0;
			changed_count <= '0;
			converged     <= 1'b0;
			unique case (act_q)
				ACT_EDGE: begin
					if (edge_ok_q) begin
						src_label     <= min_lab;
						dst_label     <= min_lab;
						label_lowered <= lower_dst || lower_src;
					end
				end
				ACT_PASS: begin
					changed_count <= count_q;
					converged     <= count_q == '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lpc_ctrl.sv
// Controller state machine: item handshake, sweeps and result register valid.
`default_nettype none
`include "label_propagation_components_defines.svh"

module lpc_ctrl import lpc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [1:0]  in_action,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output lpc_cmd_t         cmd,
	input  wire lpc_status_t status
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EDGE,
		ST_SWEEP,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	state_t      state_q;
	sweep_kind_t kind_q;
	logic        out_valid_q;

	logic accept;
	logic out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	assign cmd.accept     = accept;
	assign cmd.sweep_en   = (state_q == ST_CLEAR) || (state_q == ST_SWEEP);
	assign cmd.sweep_kind = kind_q;
	assign cmd.load_out   = ((state_q == ST_EDGE) || (state_q == ST_RESULT)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			kind_q      <= SWP_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (status.sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (action_t'(in_action))
							ACT_INIT: begin
								kind_q  <= SWP_INIT;
								state_q <= ST_SWEEP;
							end
							ACT_PASS: begin
								kind_q  <= SWP_PASS;
								state_q <= ST_SWEEP;
							end
							default: begin
								state_q <= ST_EDGE;
							end
						endcase
					end
				end
				ST_EDGE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (status.sweep_last) begin
						state_q <= (kind_q == SWP_PASS) ? ST_DRAIN : ST_RESULT;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result is never written over one that has not been taken.
	`LPC_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_q || out_ready)
	// A loaded result is presented in the next cycle.
	`LPC_ASSERT_NXT(a_load_shows, cmd.load_out, out_valid_q)
	// A sweep stops after its last entry.
	`LPC_ASSERT_NXT(a_sweep_ends, cmd.sweep_en && status.sweep_last, !cmd.sweep_en)
	// No item is taken while a sweep runs.
	`LPC_ASSERT_IMP(a_no_accept_in_sweep, cmd.sweep_en, !accept)

endmodule

`default_nettype wire

FILE: hw/rtl/label_propagation_components.sv
// Channel   Handshake            Payload
// cfg       psel/penable/pready  paddr, pwdata, prdata (node_count at byte 0)
// in        in_valid/in_ready    action, src_node, dst_node
// out       out_valid/out_ready  src_label, dst_label, label_lowered,
//                                changed_count, converged
//
// An edge item reads its two labels when it is taken, then compares them, makes at most one
// label write and loads the result. Initialize and end of pass each sweep the memories, whose
// depth is D = min(MAX_NODES, 1024), one entry a cycle; end of pass then passes a drain state.
// After reset a clearing sweep over all D entries zeroes the mark memory; in_ready stays low.
// A finished result waits in the output register while the next item is taken;
// a later result stalls until it has been taken.
`default_nettype none

module label_propagation_components import lpc_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         action,
	input  wire logic [NODE_W-1:0]  src_node,
	input  wire logic [NODE_W-1:0]  dst_node,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [LABEL_W-1:0]      src_label,
	output logic [LABEL_W-1:0]      dst_label,
	output logic                    label_lowered,
	output logic [COUNT_W-1:0]      changed_count,
	output logic                    converged
);

	logic [CFG_W-1:0] node_count_q;
	logic             reg_idx;
	lpc_cmd_t         cmd;
	lpc_status_t      status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (psel && penable && pwrite && (reg_idx == REG_NODE_COUNT)) begin
			node_count_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_NODE_COUNT) begin
			prdata = (PDATA_W)'(node_count_q);
		end
	end

	lpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (action),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	lpc_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.node_count    (node_count_q),
		.action        (action),
		.src_node      (src_node),
		.dst_node      (dst_node),
		.src_label     (src_label),
		.dst_label     (dst_label),
		.label_lowered (label_lowered),
		.changed_count (changed_count),
		.converged     (converged)
	);

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the label propagation connected-components block.
`timescale 1ns / 100ps

typedef struct packed {
	logic [lpc_pkg::LABEL_W-1:0] src_label;
	logic [lpc_pkg::LABEL_W-1:0] dst_label;
	logic                        label_lowered;
	logic [lpc_pkg::COUNT_W-1:0] changed_count;
	logic                        converged;
} lp_result_t;

// Keeps its own copy of the labels, the marks and node_count, and predicts
// one result for every accepted item.
class lp_scoreboard;
	logic [lpc_pkg::LABEL_W-1:0] labels [lpc_pkg::NODE_SPAN];
	bit                          marks [lpc_pkg::NODE_SPAN];
	logic [lpc_pkg::CFG_W-1:0]   node_count;
	lp_result_t                  pending_q[$];
	int                          errors = 0;
	int                          n_checked = 0;
	int                          n_effective = 0;
	int                          n_passes = 0;
	int                          last_count = 0;

	function new();
		int i;
		node_count = lpc_pkg::NODE_COUNT_RST;
		for (i = 0; i < lpc_pkg::NODE_SPAN; i++) begin
			labels[i] = '0;
			marks[i] = 1'b0;
		end
	endfunction

	function int nodes_in_use();
		return (node_count < lpc_pkg::MAX_NODES_DEF) ? int'(node_count) :
			lpc_pkg::MAX_NODES_DEF;
	endfunction

	function void note_input(logic [1:0] act, logic [lpc_pkg::NODE_W-1:0] s,
			logic [lpc_pkg::NODE_W-1:0] d);
		lp_result_t want;
		int used;
		int cnt;
		int i;
		want = '0;
		used = nodes_in_use();
		if (act == lpc_pkg::ACT_INIT) begin
			// Initialize always covers the whole memory, not just the nodes in use.
			for (i = 0; i < lpc_pkg::NODE_SPAN; i++) begin
				labels[i] = (lpc_pkg::LABEL_W)'(i);
				marks[i] = 1'b0;
			end
			n_effective++;
		end else if (act == lpc_pkg::ACT_EDGE) begin
			if (int'(s) < used && int'(d) < used) begin
				if (labels[s] < labels[d]) begin
					labels[d] = labels[s];
					marks[d] = 1'b1;
					want.label_lowered = 1'b1;
				end
				if (labels[d] < labels[s]) begin
					labels[s] = labels[d];
					marks[s] = 1'b1;
					want.label_lowered = 1'b1;
				end
				want.src_label = labels[s];
				want.dst_label = labels[d];
				n_effective++;
			end
		end else if (act == lpc_pkg::ACT_PASS) begin
			// Only nodes in use are counted, but every mark is cleared.
			cnt = 0;
			for (i = 0; i < lpc_pkg::NODE_SPAN; i++) begin
				if (i < used && marks[i] && cnt < lpc_pkg::COUNT_MAX)
					cnt++;
				marks[i] = 1'b0;
			end
			want.changed_count = (lpc_pkg::COUNT_W)'(cnt);
			want.converged = (cnt == 0);
			last_count = cnt;
			n_passes++;
			n_effective++;
		end
		pending_q.push_back(want);
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 30)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task check_result(lp_result_t got);
		lp_result_t want;
		if (pending_q.size() == 0) begin
			report($sformatf("result with nothing expected: src %0d dst %0d count %0d",
				got.src_label, got.dst_label, got.changed_count));
			return;
		end
		want = pending_q.pop_front();
		n_checked++;
		if (got.src_label !== want.src_label)
			report($sformatf("src_label %0d, expected %0d", got.src_label, want.src_label));
		if (got.dst_label !== want.dst_label)
			report($sformatf("dst_label %0d, expected %0d", got.dst_label, want.dst_label));
		if (got.label_lowered !== want.label_lowered)
			report($sformatf("label_lowered %b, expected %b", got.label_lowered,
				want.label_lowered));
		if (got.changed_count !== want.changed_count)
			report($sformatf("changed_count %0d, expected %0d", got.changed_count,
				want.changed_count));
		if (got.converged !== want.converged)
			report($sformatf("converged %b, expected %b", got.converged, want.converged));
	endtask
endclass

module tb;
	import lpc_pkg::*;

	localparam logic [1:0]         ACT_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT = {REG_NODE_COUNT, 2'b00};
	localparam int                 ITEMS_TARGET = 800;
	localparam int                 CYCLE_LIMIT = 1_000_000;
	localparam int                 DRAIN_CYCLES = 64;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         action = '0;
	logic [NODE_W-1:0]  src_node = '0;
	logic [NODE_W-1:0]  dst_node = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [LABEL_W-1:0] src_label;
	logic [LABEL_W-1:0] dst_label;
	logic               label_lowered;
	logic [COUNT_W-1:0] changed_count;
	logic               converged;

	lp_scoreboard sb;
	int           cycles = 0;
	int           n_sent = 0;
	int           n_cfg_writes = 0;
	bit           send_gaps = 1'b1;

	label_propagation_components u_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 92)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [NODE_W-1:0] any_node();
		return (NODE_W)'($urandom_range(0, NODE_SPAN - 1));
	endfunction

	task automatic push_item(input logic [1:0] act, input logic [NODE_W-1:0] s,
			input logic [NODE_W-1:0] d);
		in_valid <= 1'b1;
		action <= act;
		src_node <= s;
		dst_node <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(act, s, d);
		n_sent++;
		if (send_gaps && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// Waits for the block to go idle, writes node_count and reads it back.
	task automatic write_node_count(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_q.size() != 0);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_NODE_COUNT;
		pwdata <= {{(PDATA_W - CFG_W){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.node_count = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {{(PDATA_W - CFG_W){1'b0}}, v})
			sb.report($sformatf("node_count reads %0d, written %0d", prdata, v));
		psel <= 1'b0;
		penable <= 1'b0;
		n_cfg_writes++;
	endtask

	// Streams one random edge list, pass after pass, until the labels settle or max_rounds have run.
	task automatic run_graph(input int n_edges, input int max_rounds);
		int g_src[$];
		int g_dst[$];
		int used, span, base, round, k, j;
		used = sb.nodes_in_use();
		if ($urandom_range(0, 3) == 0 || used <= 8)
			span = used;
		else
			span = (used > 48) ? $urandom_range(8, 48) : used;
		base = (used > span) ? $urandom_range(0, used - span) : 0;
		for (k = 0; k < n_edges; k++) begin
			if (used == 0) begin
				g_src.push_back(int'(any_node()));
				g_dst.push_back(int'(any_node()));
			end else begin
				g_src.push_back(base + $urandom_range(0, span - 1));
				g_dst.push_back(base + $urandom_range(0, span - 1));
			end
		end
		for (round = 0; round < max_rounds; round++) begin
			for (k = 0; k < n_edges; k++) begin
				j = (round % 2) ? n_edges - 1 - k : k;
				case ($urandom_range(0, 59))
					0, 1: push_item(ACT_UNUSED, any_node(), any_node());
					2, 3, 4: push_item(ACT_EDGE, any_node(), any_node());
					5, 6: begin
						// One endpoint just past the last node in use.
						if (used > 0 && used < NODE_SPAN)
							push_item(ACT_EDGE, (NODE_W)'(g_src[j]), (NODE_W)'(used));
					end
					7: push_item(ACT_INIT, any_node(), any_node());
					default: ;
				endcase
				push_item(ACT_EDGE, (NODE_W)'(g_src[j]), (NODE_W)'(g_dst[j]));
			end
			push_item(ACT_PASS, any_node(), any_node());
			if (sb.last_count == 0)
				break;
		end
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 4) == 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(20, 200)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(lp_result_t'({src_label, dst_label, label_lowered,
				changed_count, converged}));
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.", cycles,
				sb.pending_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int phase;
		logic [CFG_W-1:0] cfg;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: field extremes, self loops, the unknown action and bit patterns.
		write_node_count(11'd1024);
		push_item(ACT_INIT, 10'd0, 10'd0);
		push_item(ACT_EDGE, 10'd0, 10'd0);
		push_item(ACT_EDGE, 10'd1023, 10'd0);
		push_item(ACT_EDGE, 10'd5, 10'd1000);
		push_item(ACT_EDGE, 10'd1000, 10'd999);
		push_item(ACT_EDGE, 10'd1023, 10'd1023);
		push_item(ACT_UNUSED, 10'd1023, 10'd1023);
		push_item(ACT_EDGE, 10'h2AA, 10'h155);
		push_item(ACT_PASS, 10'd1023, 10'd1023);
		push_item(ACT_PASS, 10'd0, 10'd0);
		push_item(ACT_EDGE, 10'd1023, 10'd1022);
		// A mark on a node above node_count is not counted but is still cleared.
		write_node_count(11'd4);
		push_item(ACT_PASS, 10'd0, 10'd0);
		write_node_count(11'd1024);
		push_item(ACT_PASS, 10'd0, 10'd0);
		// Edges that touch a node out of use are dropped.
		write_node_count(11'd4);
		push_item(ACT_EDGE, 10'd3, 10'd4);
		push_item(ACT_EDGE, 10'd4, 10'd0);
		push_item(ACT_EDGE, 10'd0, 10'd1023);
		push_item(ACT_EDGE, 10'd3, 10'd0);
		push_item(ACT_PASS, 10'd0, 10'd0);
		write_node_count(11'd0);
		push_item(ACT_EDGE, 10'd0, 10'd0);
		push_item(ACT_PASS, 10'd0, 10'd0);
		// Initialize with few nodes in use must still reset the whole memory.
		write_node_count(11'd2);
		push_item(ACT_INIT, 10'd0, 10'd0);
		push_item(ACT_EDGE, 10'd1, 10'd0);
		push_item(ACT_PASS, 10'd0, 10'd0);
		write_node_count(11'd1024);
		push_item(ACT_EDGE, 10'd1023, 10'd512);
		push_item(ACT_PASS, 10'd0, 10'd0);

		phase = 0;
		while (n_sent < ITEMS_TARGET) begin
			case (phase)
				0: cfg = 11'd1;
				1: cfg = 11'd2047;
				default: begin
					case ($urandom_range(0, 9))
						0: cfg = 11'd0;
						1: cfg = 11'd1;
						2: cfg = 11'd2;
						3: cfg = 11'd1024;
						4: cfg = 11'd2047;
						5: cfg = (CFG_W)'($urandom_range(1025, 2046));
						default: cfg = (CFG_W)'($urandom_range(3, 64));
					endcase
				end
			endcase
			write_node_count(cfg);
			send_gaps = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) != 0)
				push_item(ACT_INIT, any_node(), any_node());
			run_graph($urandom_range(6, 40), 6);
			phase++;
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d items (%0d initialize, edge-in-use or pass), %0d results checked.",
			n_sent, sb.n_effective, sb.n_checked);
		$display("Went through %0d node_count writes and %0d end-of-pass sweeps; %0d mismatches.",
			n_cfg_writes, sb.n_passes, sb.errors);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/lpc_pkg.sv
hw/rtl/lpc_datapath.sv
hw/rtl/lpc_ctrl.sv
hw/rtl/label_propagation_components.sv
bench/tb.sv
